/* sv/m3ip_pkg.sv */
package m3ip_pkg;

	localparam int DATA_W        = 64;
	localparam int N_ENT         = 9;
	localparam int EXP_W         = 6;
	localparam int IN_W          = 584;
	localparam int OUT_W         = 576;
	localparam int MAX_POWER_DEF = 16;
	localparam int FRAC_BITS_DEF = 32;

	localparam logic [63:0] VMAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] VMIN   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SING_K = 64'd12345678;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct packed {
		logic  [DATA_W-1:0] v;
		logic               o;
	} sres_t;

	// reply of the multiplier or the divider
	typedef struct packed {
		logic               done;
		logic  [DATA_W-1:0] v;
		logic               o;
	} unit_rsp_t;

	function automatic sres_t sadd(word_t a, word_t b);
		sres_t r;
		r.v = a + b;
		r.o = 1'b0;
		if (a[63] == b[63] && r.v[63] != a[63]) begin
			r.o = 1'b1;
			r.v = a[63] ? VMIN : VMAX;
		end
		return r;
	endfunction

	function automatic sres_t ssub(word_t a, word_t b);
		sres_t r;
		r.v = a - b;
		r.o = 1'b0;
		if (a[63] != b[63] && r.v[63] != a[63]) begin
			r.o = 1'b1;
			r.v = a[63] ? VMIN : VMAX;
		end
		return r;
	endfunction

	function automatic sres_t sneg(word_t a);
		sres_t r;
		r.o = (a == VMIN);
		r.v = r.o ? VMAX : (64'd0 - a);
		return r;
	endfunction

	// diagonal value used when the determinant is zero
	function automatic sres_t sing_base(int f);
		sres_t r;
		r.o = (SING_K > (VMAX >> f));
		r.v = r.o ? VMAX : (SING_K << f);
		return r;
	endfunction

	// cofactor k is e[p]*e[q] - e[s]*e[t], packed as {p, q, s, t}
	function automatic logic [15:0] cof_ops(logic [3:0] k);
		logic [15:0] r;
		unique case (k)
			4'd0:    r = {4'd4, 4'd8, 4'd5, 4'd7};
			4'd1:    r = {4'd1, 4'd8, 4'd2, 4'd7};
			4'd2:    r = {4'd1, 4'd5, 4'd2, 4'd4};
			4'd3:    r = {4'd3, 4'd8, 4'd5, 4'd6};
			4'd4:    r = {4'd0, 4'd8, 4'd2, 4'd6};
			4'd5:    r = {4'd0, 4'd5, 4'd2, 4'd3};
			4'd6:    r = {4'd3, 4'd7, 4'd4, 4'd6};
			4'd7:    r = {4'd0, 4'd7, 4'd1, 4'd6};
			4'd8:    r = {4'd0, 4'd4, 4'd1, 4'd3};
			default: r = '0;
		endcase
		return r;
	endfunction

	// the three minors of the determinant go first
	function automatic logic [3:0] cof_slot(logic [3:0] s);
		logic [3:0] r;
		unique case (s)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd3;
			4'd2:    r = 4'd6;
			4'd3:    r = 4'd1;
			4'd4:    r = 4'd2;
			4'd5:    r = 4'd4;
			4'd6:    r = 4'd5;
			4'd7:    r = 4'd7;
			4'd8:    r = 4'd8;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] mm_row(logic [3:0] k);
		logic [1:0] r;
		unique case (k)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] mm_col(logic [3:0] k);
		logic [1:0] r;
		unique case (k)
			4'd0, 4'd3, 4'd6: r = 2'd0;
			4'd1, 4'd4, 4'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

/* sv/m3ip_mul.sv */
module m3ip_mul #(
	parameter int FRAC_BITS = m3ip_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  m3ip_pkg::word_t     a,
	input  m3ip_pkg::word_t     b,
	output m3ip_pkg::unit_rsp_t rsp
);

	localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);

	logic         busy_q;
	logic [2:0]   step_q;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [127:0] acc_q;
	m3ip_pkg::unit_rsp_t rsp_q;

	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [127:0] rnd;
	logic [64-FRAC_BITS:0] top;
	logic         fits;

	always_comb begin
		pa = step_q[1] ? ma_q[63:32] : ma_q[31:0];
		pb = step_q[0] ? mb_q[63:32] : mb_q[31:0];
		pp = pa * pb;
		case (step_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		rnd  = acc_q + RND;
		top  = rnd[127:FRAC_BITS+63];
		fits = (top == '0) || (&top);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= '0;
			rsp_q.done <= 1'b0;
		end else begin
			rsp_q.done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				ma_q   <= a[63] ? 64'd0 - a : a;
				mb_q   <= b[63] ? 64'd0 - b : b;
				neg_q  <= a[63] ^ b[63];
				acc_q  <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q < 3'd4) begin
					acc_q <= acc_q + pp_sh;
				end else if (step_q == 3'd4) begin
					if (neg_q)
						acc_q <= 128'd0 - acc_q;
				end else begin
					busy_q     <= 1'b0;
					rsp_q.done <= 1'b1;
					rsp_q.o    <= !fits;
					rsp_q.v    <= fits ? rnd[FRAC_BITS+63:FRAC_BITS] :
						(rnd[127] ? m3ip_pkg::VMIN : m3ip_pkg::VMAX);
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

/* sv/m3ip_div.sv */
module m3ip_div #(
	parameter int FRAC_BITS = m3ip_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  m3ip_pkg::word_t     c,
	input  m3ip_pkg::word_t     d,
	output m3ip_pkg::unit_rsp_t rsp
);

	logic         busy_q;
	logic         fin_q;
	logic [6:0]   cnt_q;
	logic [127:0] num_q;
	logic [127:0] quo_q;
	logic [63:0]  rem_q, md_q;
	logic         neg_q;
	m3ip_pkg::unit_rsp_t rsp_q;

	logic [63:0]  mc, rs, rem_n, lim;
	logic         ge, rup, sat;
	logic [127:0] qr;

	always_comb begin
		mc    = c[63] ? 64'd0 - c : c;
		rs    = {rem_q[62:0], num_q[127]};
		ge    = rem_q[63] || (rs >= md_q);
		rem_n = ge ? rs - md_q : rs;
		rup   = (rem_q >= md_q - rem_q);
		qr    = quo_q + {127'd0, rup};
		lim   = neg_q ? m3ip_pkg::VMIN : m3ip_pkg::VMAX;
		sat   = (qr[127:64] != '0) || (qr[63:0] > lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			fin_q      <= 1'b0;
			cnt_q      <= '0;
			rsp_q.done <= 1'b0;
		end else begin
			rsp_q.done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= '0;
				num_q  <= {64'd0, mc} << FRAC_BITS;
				quo_q  <= '0;
				rem_q  <= '0;
				md_q   <= d[63] ? 64'd0 - d : d;
				neg_q  <= c[63] ^ d[63];
			end else if (busy_q && !fin_q) begin
				// one quotient bit a cycle
				num_q <= {num_q[126:0], 1'b0};
				rem_q <= rem_n;
				quo_q <= {quo_q[126:0], ge};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127)
					fin_q <= 1'b1;
			end else if (busy_q) begin
				busy_q     <= 1'b0;
				fin_q      <= 1'b0;
				rsp_q.done <= 1'b1;
				rsp_q.o    <= sat;
				rsp_q.v    <= sat ? lim : (neg_q ? 64'd0 - qr[63:0] : qr[63:0]);
			end
		end
	end

	assign rsp = rsp_q;

endmodule

/* sv/matrix3_inverse_power.sv */
// 3x3 signed fixed-point matrix integer power. One word in carries the nine entries and
// a signed exponent; one word out carries the result and the singular/overflow flags.
// Exponent zero returns the identity. Otherwise every product goes
// through one shared 64x64 multiplier built from a 32x32 array. A negative
// exponent first builds the inverse: 21 products plus 9 quotients from a bit-serial
// divider; a zero determinant gives a diagonal base instead. The block takes no new
// word while it works; a finished word waits in the output register.
module matrix3_inverse_power #(
	parameter int MAX_POWER = m3ip_pkg::MAX_POWER_DEF,
	parameter int FRAC_BITS = m3ip_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// a00, a01, a02, a10, a11, a12, a20, a21, a22, exponent, zero fill
	input  logic [m3ip_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22
	output logic [m3ip_pkg::OUT_W-1:0] m_axis_tdata,
	// singular, overflow
	output logic [1:0]                 m_axis_tuser
);

	localparam int CNT_W = $clog2(MAX_POWER + 1);
	localparam m3ip_pkg::sres_t SING_B = m3ip_pkg::sing_base(FRAC_BITS);
	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

	typedef enum logic [2:0] {S_IDLE, S_COF, S_DET, S_DIV, S_PSET, S_MM, S_OUT} state_t;
	typedef enum logic [1:0] {P_LDA, P_ISSUE, P_WAIT} step_t;

	state_t state_q;
	step_t  sub_q;
	logic [3:0] slot_q;
	logic [1:0] ph_q;
	logic [CNT_W-1:0] n_q, cnt_q;
	logic ovf_q, sing_q;
	logic m_valid_q, sing_out_q, ovf_out_q;
	m3ip_pkg::word_t e_q [9];
	m3ip_pkg::word_t b_q [9];
	m3ip_pkg::word_t r_q [9];
	m3ip_pkg::word_t t_q [9];
	m3ip_pkg::word_t out_q [9];
	m3ip_pkg::word_t op_a_q, acc_q, det_q;

	logic [5:0] ex_in;
	logic [6:0] mag_in;
	logic [CNT_W-1:0] n_in;
	logic [3:0] k_cof, e_addr, b_addr, r_addr;
	logic [15:0] ops;
	logic [1:0] mm_i, mm_j;
	m3ip_pkg::word_t e_rd, b_rd, r_rd, mul_b, dvd;
	m3ip_pkg::sres_t neg_b, acc_sub, acc_add;
	logic mul_start, div_start;
	m3ip_pkg::unit_rsp_t mrsp, drsp;

	always_comb begin
		ex_in  = s_axis_tdata[581:576];
		mag_in = ex_in[5] ? 7'd64 - {1'b0, ex_in} : {1'b0, ex_in};
		n_in   = (mag_in > 7'(MAX_POWER)) ? CNT_W'(MAX_POWER) : CNT_W'(mag_in);

		k_cof = m3ip_pkg::cof_slot(slot_q);
		ops   = m3ip_pkg::cof_ops(k_cof);
		mm_i  = m3ip_pkg::mm_row(slot_q);
		mm_j  = m3ip_pkg::mm_col(slot_q);

		unique case (state_q)
			S_COF: begin
				if (sub_q == P_LDA)
					e_addr = ph_q[0] ? ops[7:4] : ops[15:12];
				else
					e_addr = ph_q[0] ? ops[3:0] : ops[11:8];
			end
			S_DET:   e_addr = {2'b00, ph_q};
			default: e_addr = '0;
		endcase
		unique case (state_q)
			S_DET:   b_addr = 4'(ph_q * 3);
			S_DIV:   b_addr = slot_q;
			default: b_addr = 4'(ph_q * 3 + mm_j);
		endcase
		r_addr = 4'(mm_i * 3 + ph_q);

		e_rd = e_q[e_addr];
		b_rd = b_q[b_addr];
		r_rd = r_q[r_addr];

		mul_b = (state_q == S_COF) ? e_rd : b_rd;
		neg_b = m3ip_pkg::sneg(b_rd);
		// odd cofactors carry the minus sign
		dvd   = slot_q[0] ? neg_b.v : b_rd;

		acc_sub = m3ip_pkg::ssub(acc_q, mrsp.v);
		acc_add = m3ip_pkg::sadd(acc_q, mrsp.v);

		mul_start = (sub_q == P_ISSUE) &&
			(state_q == S_COF || state_q == S_DET || state_q == S_MM);
		div_start = (sub_q == P_ISSUE) && (state_q == S_DIV);
	end

	m3ip_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a_q),
		.b      (mul_b),
		.rsp    (mrsp)
	);

	m3ip_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.c      (dvd),
		.d      (det_q),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sub_q     <= P_LDA;
			slot_q    <= '0;
			ph_q      <= '0;
			n_q       <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			sing_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != S_OUT)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						for (int i = 0; i < 9; i++) begin
							e_q[i] <= s_axis_tdata[i*64 +: 64];
							b_q[i] <= s_axis_tdata[i*64 +: 64];
						end
						ovf_q  <= 1'b0;
						sing_q <= 1'b0;
						n_q    <= n_in;
						slot_q <= '0;
						ph_q   <= '0;
						sub_q  <= P_LDA;
						if (n_in == '0) begin
							for (int i = 0; i < 9; i++)
								r_q[i] <= (i % 4 == 0) ? ONE : '0;
							state_q <= S_OUT;
						end else if (ex_in[5]) begin
							state_q <= S_COF;
						end else begin
							state_q <= S_PSET;
						end
					end
				end
				S_COF: begin
					unique case (sub_q)
						P_LDA: begin
							op_a_q <= e_rd;
							sub_q  <= P_ISSUE;
						end
						P_ISSUE: sub_q <= P_WAIT;
						default: begin
							if (mrsp.done) begin
								if (ph_q == 2'd0) begin
									sub_q <= P_LDA;
									acc_q <= mrsp.v;
									ovf_q <= ovf_q | mrsp.o;
									ph_q  <= 2'd1;
								end else begin
									b_q[k_cof] <= acc_sub.v;
									ovf_q  <= ovf_q | mrsp.o | acc_sub.o;
									ph_q   <= 2'd0;
									if (slot_q == 4'd8) begin
										state_q <= S_DIV;
										slot_q  <= '0;
										sub_q   <= P_ISSUE;
									end else begin
										slot_q <= slot_q + 4'd1;
										sub_q  <= P_LDA;
										if (slot_q == 4'd2)
											state_q <= S_DET;
									end
								end
							end
						end
					endcase
				end
				S_DET: begin
					unique case (sub_q)
						P_LDA: begin
							op_a_q <= e_rd;
							sub_q  <= P_ISSUE;
						end
						P_ISSUE: sub_q <= P_WAIT;
						default: begin
							if (mrsp.done) begin
								sub_q <= P_LDA;
								if (ph_q == 2'd0) begin
									acc_q <= mrsp.v;
									ovf_q <= ovf_q | mrsp.o;
									ph_q  <= 2'd1;
								end else if (ph_q == 2'd1) begin
									acc_q <= acc_sub.v;
									ovf_q <= ovf_q | mrsp.o | acc_sub.o;
									ph_q  <= 2'd2;
								end else begin
									det_q <= acc_add.v;
									ph_q  <= '0;
									if (acc_add.v == '0) begin
										sing_q <= 1'b1;
										ovf_q  <= ovf_q | mrsp.o | acc_add.o | SING_B.o;
										for (int i = 0; i < 9; i++)
											b_q[i] <= (i % 4 == 0) ? SING_B.v : '0;
										state_q <= S_PSET;
									end else begin
										ovf_q   <= ovf_q | mrsp.o | acc_add.o;
										slot_q  <= 4'd3;
										state_q <= S_COF;
									end
								end
							end
						end
					endcase
				end
				S_DIV: begin
					if (sub_q == P_ISSUE) begin
						ovf_q <= ovf_q | (slot_q[0] & neg_b.o);
						sub_q <= P_WAIT;
					end else if (drsp.done) begin
						b_q[slot_q] <= drsp.v;
						ovf_q <= ovf_q | drsp.o;
						if (slot_q == 4'd8) begin
							state_q <= S_PSET;
						end else begin
							slot_q <= slot_q + 4'd1;
							sub_q  <= P_ISSUE;
						end
					end
				end
				S_PSET: begin
					for (int i = 0; i < 9; i++)
						r_q[i] <= b_q[i];
					cnt_q  <= CNT_W'(1);
					slot_q <= '0;
					ph_q   <= '0;
					sub_q  <= P_LDA;
					state_q <= (n_q == CNT_W'(1)) ? S_OUT : S_MM;
				end
				S_MM: begin
					unique case (sub_q)
						P_LDA: begin
							op_a_q <= r_rd;
							sub_q  <= P_ISSUE;
						end
						P_ISSUE: sub_q <= P_WAIT;
						default: begin
							if (mrsp.done) begin
								sub_q <= P_LDA;
								if (ph_q == 2'd0) begin
									acc_q <= mrsp.v;
									ovf_q <= ovf_q | mrsp.o;
									ph_q  <= 2'd1;
								end else if (ph_q == 2'd1) begin
									acc_q <= acc_add.v;
									ovf_q <= ovf_q | mrsp.o | acc_add.o;
									ph_q  <= 2'd2;
								end else begin
									t_q[slot_q] <= acc_add.v;
									ovf_q <= ovf_q | mrsp.o | acc_add.o;
									ph_q  <= '0;
									if (slot_q == 4'd8) begin
										// whole product ready, it becomes the left operand
										for (int i = 0; i < 8; i++)
											r_q[i] <= t_q[i];
										r_q[8] <= acc_add.v;
										slot_q <= '0;
										cnt_q  <= cnt_q + CNT_W'(1);
										if (CNT_W'(cnt_q + CNT_W'(1)) == n_q)
											state_q <= S_OUT;
									end else begin
										slot_q <= slot_q + 4'd1;
									end
								end
							end
						end
					endcase
				end
				default: begin
					if (!m_valid_q || m_axis_tready) begin
						for (int i = 0; i < 9; i++)
							out_q[i] <= r_q[i];
						sing_out_q <= sing_q;
						ovf_out_q  <= ovf_q;
						m_valid_q  <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++)
			m_axis_tdata[i*64 +: 64] = out_q[i];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = {ovf_out_q, sing_out_q};

endmodule

/* sv/m3ip_chk.sv */
module m3ip_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic [m3ip_pkg::IN_W-1:0]  s_axis_tdata,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [m3ip_pkg::OUT_W-1:0] m_axis_tdata,
	input logic [1:0]                 m_axis_tuser
);

	// output word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// a new result comes out of a busy phase
	a_new_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without work");

	// a singular base is diagonal, so is every power of it
	a_sing_diag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[127:64] == '0
		&& m_axis_tdata[191:128] == '0 && m_axis_tdata[255:192] == '0
		&& m_axis_tdata[383:320] == '0 && m_axis_tdata[447:384] == '0
		&& m_axis_tdata[511:448] == '0)
		else $error("singular result not diagonal");

endmodule

bind matrix3_inverse_power m3ip_chk u_m3ip_chk (.*);

/* tb/sv/tb_matrix3_inverse_power.sv */
module tb_matrix3_inverse_power;

	localparam int N_ENT  = m3ip_pkg::N_ENT;
	localparam int DATA_W = m3ip_pkg::DATA_W;
	localparam int EXP_W  = m3ip_pkg::EXP_W;
	localparam int IN_W   = m3ip_pkg::IN_W;
	localparam int OUT_W  = m3ip_pkg::OUT_W;
	localparam logic [63:0] VMAX   = m3ip_pkg::VMAX;
	localparam logic [63:0] VMIN   = m3ip_pkg::VMIN;
	localparam logic [63:0] SING_K = m3ip_pkg::SING_K;
	localparam int FRAC = m3ip_pkg::FRAC_BITS_DEF;
	localparam int POWER_CAP = m3ip_pkg::MAX_POWER_DEF;

	typedef m3ip_pkg::word_t word_t;
	typedef logic [N_ENT-1:0][DATA_W-1:0] mat_t;

	typedef struct packed {
		mat_t m;
		logic sing;
		logic ovf;
	} power_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic [1:0]         m_axis_tuser;

	power_result_t pending_results[$];
	int  errors = 0;
	int  words_sent = 0;
	int  words_checked = 0;
	int  singular_seen = 0;
	int  overflow_seen = 0;
	int  inverse_sent = 0;
	bit  quiet = 1'b0;
	int  hold_left = 0;
	bit  sat_flag;

	matrix3_inverse_power dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	// saturating fixed-point helpers, flag collected in sat_flag
	function automatic word_t sat_add(word_t a, word_t b);
		word_t r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) begin
			sat_flag = 1'b1;
			r = a[63] ? VMIN : VMAX;
		end
		return r;
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		word_t r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63]) begin
			sat_flag = 1'b1;
			r = a[63] ? VMIN : VMAX;
		end
		return r;
	endfunction

	function automatic word_t sat_neg(word_t a);
		if (a == VMIN) begin
			sat_flag = 1'b1;
			return VMAX;
		end
		return 64'd0 - a;
	endfunction

	function automatic word_t fx_mul(word_t a, word_t b);
		logic signed [127:0] p;
		p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		p = p + (128'sd1 <<< (FRAC - 1));
		p = p >>> FRAC;
		if (p[127:63] != {65{p[127]}}) begin
			sat_flag = 1'b1;
			return p[127] ? VMIN : VMAX;
		end
		return p[63:0];
	endfunction

	function automatic word_t fx_div(word_t c, word_t d);
		logic [127:0] num, q, rm, lim, md;
		word_t mc;
		bit ng;
		mc = c[63] ? 64'd0 - c : c;
		md = {64'd0, (d[63] ? 64'd0 - d : d)};
		ng = c[63] != d[63];
		num = {64'd0, mc} << FRAC;
		q = num / md;
		rm = num % md;
		if (rm >= md - rm)
			q = q + 1;
		lim = ng ? {64'd0, VMIN} : {64'd0, VMAX};
		if (q > lim) begin
			sat_flag = 1'b1;
			return lim[63:0];
		end
		return ng ? 64'd0 - q[63:0] : q[63:0];
	endfunction

	function automatic word_t cofactor(mat_t e, int p, int q, int s, int t);
		return sat_sub(fx_mul(e[p], e[q]), fx_mul(e[s], e[t]));
	endfunction

	function automatic mat_t mat_mul(mat_t x, mat_t y);
		mat_t o;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				o[i*3+j] = sat_add(sat_add(fx_mul(x[i*3], y[j]),
					fx_mul(x[i*3+1], y[3+j])), fx_mul(x[i*3+2], y[6+j]));
		return o;
	endfunction

	function automatic power_result_t matrix_power(mat_t e, logic [EXP_W-1:0] ex);
		power_result_t res;
		mat_t base;
		word_t det;
		int n;
		sat_flag = 1'b0;
		res.sing = 1'b0;
		n = ex[EXP_W-1] ? 64 - int'(ex) : int'(ex);
		if (n > POWER_CAP)
			n = POWER_CAP;
		if (n == 0) begin
			res.m = '0;
			res.m[0] = word_t'(1) << FRAC;
			res.m[4] = word_t'(1) << FRAC;
			res.m[8] = word_t'(1) << FRAC;
		end else begin
			base = e;
			if (ex[EXP_W-1]) begin
				det = sat_add(sat_sub(fx_mul(e[0], cofactor(e, 4, 8, 5, 7)),
					fx_mul(e[1], cofactor(e, 3, 8, 5, 6))),
					fx_mul(e[2], cofactor(e, 3, 7, 4, 6)));
				if (det != 0) begin
					base[0] = fx_div(cofactor(e, 4, 8, 5, 7), det);
					base[3] = fx_div(sat_neg(cofactor(e, 3, 8, 5, 6)), det);
					base[6] = fx_div(cofactor(e, 3, 7, 4, 6), det);
					base[1] = fx_div(sat_neg(cofactor(e, 1, 8, 2, 7)), det);
					base[4] = fx_div(cofactor(e, 0, 8, 2, 6), det);
					base[7] = fx_div(sat_neg(cofactor(e, 0, 7, 1, 6)), det);
					base[2] = fx_div(cofactor(e, 1, 5, 2, 4), det);
					base[5] = fx_div(sat_neg(cofactor(e, 0, 5, 2, 3)), det);
					base[8] = fx_div(cofactor(e, 0, 4, 1, 3), det);
				end else begin
					res.sing = 1'b1;
					base = '0;
					if (SING_K > (VMAX >> FRAC)) begin
						sat_flag = 1'b1;
						base[0] = VMAX;
					end else begin
						base[0] = SING_K << FRAC;
					end
					base[4] = base[0];
					base[8] = base[0];
				end
			end
			res.m = base;
			for (int i = 1; i < n; i++)
				res.m = mat_mul(res.m, base);
		end
		res.ovf = sat_flag;
		return res;
	endfunction

	task automatic send_matrix(mat_t m, int ex);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, 6'(ex), m};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(matrix_power(m, 6'(ex)));
		words_sent++;
		if (ex < 0)
			inverse_sent++;
		@(negedge clk);
	endtask

	function automatic word_t int_fx(int v);
		return word_t'(longint'(v)) << FRAC;
	endfunction

	function automatic word_t rand_entry();
		word_t w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       return w;
			1:       return $urandom_range(0, 1) ? VMAX : VMIN;
			2:       return 64'd0;
			3, 4:    return int_fx($signed($urandom_range(0, 8)) - 4);
			default: return {{28{w[35]}}, w[35:0]};
		endcase
	endfunction

	function automatic mat_t rand_matrix();
		mat_t m;
		for (int i = 0; i < N_ENT; i++)
			m[i] = rand_entry();
		// some bases are made singular by repeating a row
		if ($urandom_range(0, 5) == 0)
			for (int j = 0; j < 3; j++)
				m[6+j] = m[j];
		return m;
	endfunction

	function automatic int rand_exponent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 6) - 3;
		if (r < 95)
			return $urandom_range(0, 12) - 6;
		return $urandom_range(0, 32) - 16;
	endfunction

	function automatic mat_t diag(word_t v);
		mat_t m;
		m = '0;
		m[0] = v;
		m[4] = v;
		m[8] = v;
		return m;
	endfunction

	// receiver with random stall bursts and an optional long hold-off
	initial begin
		int stall;
		bit rdy;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (quiet) begin
				rdy = 1'b1;
			end else if (stall > 0) begin
				stall--;
				rdy = 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14) - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_axis_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		power_result_t want;
		mat_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_results.size() == 0) begin
				$error("result word with no expectation waiting");
				errors++;
			end else begin
				want = pending_results.pop_front();
				words_checked++;
				if (want.sing)
					singular_seen++;
				if (want.ovf)
					overflow_seen++;
				for (int i = 0; i < N_ENT; i++)
					if (got[i] !== want.m[i]) begin
						$error("r%0d%0d: expected %h actual %h", i / 3, i % 3,
							want.m[i], got[i]);
						errors++;
					end
				if (m_axis_tuser[0] !== want.sing) begin
					$error("singular: expected %b actual %b", want.sing, m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tuser[1] !== want.ovf) begin
					$error("overflow: expected %b actual %b", want.ovf, m_axis_tuser[1]);
					errors++;
				end
			end
		end
	end

	task automatic test_identity_power();
		send_matrix(rand_matrix(), 0);
		send_matrix(diag(VMIN), 0);
	endtask

	task automatic test_positive_power();
		mat_t m;
		for (int i = 0; i < N_ENT; i++)
			m[i] = int_fx(i % 3 - 1);
		send_matrix(m, 1);
		send_matrix(m, 2);
		send_matrix(diag(int_fx(1) >> 1), 16);
		send_matrix(rand_matrix(), 3);
	endtask

	task automatic test_inverse();
		mat_t m;
		m = diag(int_fx(2));
		m[1] = int_fx(1);
		m[5] = int_fx(-3);
		send_matrix(m, -1);
		send_matrix(m, -2);
		send_matrix(diag(int_fx(1)), -16);
		send_matrix(rand_matrix(), -1);
	endtask

	task automatic test_singular_base();
		mat_t m;
		m = diag(int_fx(3));
		m[8] = 64'd0;
		send_matrix(m, -1);
		send_matrix('0, -3);
		send_matrix(m, -16);
	endtask

	task automatic test_saturation();
		mat_t m;
		for (int i = 0; i < N_ENT; i++)
			m[i] = VMAX;
		send_matrix(m, 2);
		for (int i = 0; i < N_ENT; i++)
			m[i] = VMIN;
		send_matrix(m, 1);
		send_matrix(m, -1);
		send_matrix(diag(VMIN), -1);
		send_matrix(diag(64'd1), -1);
		send_matrix(diag(VMAX), -2);
		send_matrix(diag(VMIN), 16);
	endtask

	task automatic test_output_stall();
		hold_left = 3000;
		for (int i = 0; i < 4; i++)
			send_matrix(rand_matrix(), $urandom_range(0, 4) - 2);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i == count - count / 8)
				quiet = 1'b1;
			send_matrix(rand_matrix(), rand_exponent());
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_identity_power();
		test_positive_power();
		test_inverse();
		test_singular_base();
		test_saturation();
		test_output_stall();
		test_random(400);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end
		$display("sent %0d matrices (%0d with negative exponent), checked %0d results",
			words_sent, inverse_sent, words_checked);
		$display("results with singular base: %0d, with saturation: %0d",
			singular_seen, overflow_seen);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#200000000;
		$display("FAIL");
		$finish;
	end

endmodule

/* matrix3_inverse_power.f */
sv/m3ip_pkg.sv
sv/m3ip_mul.sv
sv/m3ip_div.sv
sv/matrix3_inverse_power.sv
sv/m3ip_chk.sv
tb/sv/tb_matrix3_inverse_power.sv
